/* rtl/dq_pkg.sv */
// ----------------------------------------------------------------------------
// dq_pkg
// Shared types and codes for the double-ended queue core: command and status
// codes, sequencer states and the beat payload structs.
// ----------------------------------------------------------------------------
package dq_pkg;

    localparam int VAL_W = 32;
    localparam int LEN_W = 7;

    typedef enum logic [2:0] {
        CMD_PUSH_FRONT = 3'd0,
        CMD_PUSH_BACK  = 3'd1,
        CMD_POP_FRONT  = 3'd2,
        CMD_POP_BACK   = 3'd3,
        CMD_CLEAR      = 3'd4,
        CMD_REMOVE     = 3'd5,
        CMD_READ_FIRST = 3'd6,
        CMD_READ_LAST  = 3'd7
    } cmd_e_t;

    typedef enum logic [2:0] {
        KIND_DONE    = 3'd0,
        KIND_FULL    = 3'd1,
        KIND_EMPTY   = 3'd2,
        KIND_ELEMENT = 3'd3,
        KIND_NONE    = 3'd4
    } kind_e_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_REMOVE,
        S_RD_FIRST,
        S_RD_EMIT
    } state_e_t;

    typedef struct packed {
        logic [2:0]              cmd;
        logic signed [VAL_W-1:0] item_value;
        logic [LEN_W-1:0]        read_count;
    } in_t;

    typedef struct packed {
        logic [2:0]              kind;
        logic signed [VAL_W-1:0] out_value;
        logic [LEN_W-1:0]        length;
        logic                    is_last;
    } out_t;

endpackage

/* rtl/dq_ram.sv */
// ----------------------------------------------------------------------------
// dq_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module dq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* rtl/deque_with_value_delete_core.sv */
// ----------------------------------------------------------------------------
// deque_with_value_delete_core
// Bounded double-ended queue of signed 32-bit words in a ring RAM, with
// push/pop at both ends, clear, remove-by-value and read of first/last n.
// ----------------------------------------------------------------------------
// Usage: one command beat enters on in_data (valid/ready); result beats leave
// on out_data (valid/ready) through a single output register. Every command
// gives one result beat with is_last set, except reads of n > 0 entries,
// which give n element beats in queue order, the final one with is_last set.
// Push, pop and clear finish in the accept cycle: the result is in the output
// register in the following cycle, so these run at one command per cycle
// while the receiver keeps up. Remove walks the whole queue through the RAM
// read port and a single compare, one entry per cycle. Reads fetch the first
// element through the registered RAM read, then give one element per cycle
// while the receiver keeps up. A new command is taken only when the sequencer
// is idle and the output register is empty or being emptied in the same cycle.
// A stalled receiver holds the output register and halts the read walk.
// Reset empties the queue (head and count to zero); RAM contents are left as
// they are and only written entries are ever read.
// ----------------------------------------------------------------------------
module deque_with_value_delete_core
    import dq_pkg::*;
#(
    parameter int DEPTH = 32
) (
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_ready,
    input  in_t  in_data,
    output logic out_valid,
    input  logic out_ready,
    output out_t out_data
);

    localparam int IDX_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    function automatic logic [IDX_W-1:0] ring_slot(
        input logic [IDX_W-1:0] base,
        input logic [CNT_W-1:0] off
    );
        logic [CNT_W:0] sum;
        sum = (CNT_W+1)'(base) + (CNT_W+1)'(off);
        if (sum >= (CNT_W+1)'(DEPTH))
        begin
            sum = sum - (CNT_W+1)'(DEPTH);
        end
        return sum[IDX_W-1:0];
    endfunction

    state_e_t                state_reg, state_next;
    logic [IDX_W-1:0]        head_reg, head_next;
    logic [CNT_W-1:0]        count_reg, count_next;
    logic [CNT_W-1:0]        idx_reg, idx_next;
    logic [CNT_W-1:0]        wr_reg, wr_next;
    logic [CNT_W-1:0]        n_reg, n_next;
    logic [CNT_W-1:0]        start_reg, start_next;
    logic                    pend_reg, pend_next;
    logic signed [VAL_W-1:0] value_reg, value_next;
    logic                    out_valid_reg, out_valid_next;
    out_t                    out_reg, out_next;

    logic                    ram_we;
    logic [IDX_W-1:0]        ram_waddr;
    logic [VAL_W-1:0]        ram_wdata;
    logic                    ram_re;
    logic [IDX_W-1:0]        ram_raddr;
    logic [VAL_W-1:0]        ram_rdata;

    logic                    out_free;
    logic                    in_fire;
    logic                    is_full;
    logic                    is_empty;
    logic [CNT_W-1:0]        rd_n;
    logic [IDX_W-1:0]        head_dec;
    logic [CNT_W-1:0]        rd_off;

    dq_ram #(
        .WIDTH (VAL_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign out_free  = !out_valid_reg || out_ready;
    assign in_ready  = (state_reg == S_IDLE) && out_free;
    assign in_fire   = in_valid && in_ready;
    assign is_full   = (count_reg == CNT_W'(DEPTH));
    assign is_empty  = (count_reg == '0);
    assign head_dec  = (head_reg == '0) ? IDX_W'(DEPTH - 1) : head_reg - 1'b1;
    // clamp the requested read length to what the queue holds
    assign rd_n      = (in_data.read_count < LEN_W'(count_reg))
                       ? in_data.read_count[CNT_W-1:0] : count_reg;

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            head_reg      <= '0;
            count_reg     <= '0;
            idx_reg       <= '0;
            wr_reg        <= '0;
            n_reg         <= '0;
            start_reg     <= '0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            count_reg     <= count_next;
            idx_reg       <= idx_next;
            wr_reg        <= wr_next;
            n_reg         <= n_next;
            start_reg     <= start_next;
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
        out_reg   <= out_next;
    end

    always_comb
    begin
        state_next     = state_reg;
        head_next      = head_reg;
        count_next     = count_reg;
        idx_next       = idx_reg;
        wr_next        = wr_reg;
        n_next         = n_reg;
        start_next     = start_reg;
        pend_next      = 1'b0;
        value_next     = value_reg;
        out_valid_next = out_valid_reg && !out_ready;
        out_next       = out_reg;
        ram_we         = 1'b0;
        ram_waddr      = ring_slot(head_reg, wr_reg);
        ram_wdata      = VAL_W'(in_data.item_value);
        ram_re         = 1'b0;
        rd_off         = start_reg + idx_reg;
        ram_raddr      = ring_slot(head_reg, idx_reg);

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    out_next.kind      = KIND_DONE;
                    out_next.out_value = '0;
                    out_next.is_last   = 1'b1;
                    value_next         = in_data.item_value;
                    unique case (cmd_e_t'(in_data.cmd))
                        CMD_PUSH_FRONT:
                        begin
                            if (is_full)
                            begin
                                out_next.kind = KIND_FULL;
                            end
                            else
                            begin
                                head_next  = head_dec;
                                count_next = count_reg + 1'b1;
                                ram_we     = 1'b1;
                                ram_waddr  = head_dec;
                            end
                        end
                        CMD_PUSH_BACK:
                        begin
                            if (is_full)
                            begin
                                out_next.kind = KIND_FULL;
                            end
                            else
                            begin
                                count_next = count_reg + 1'b1;
                                ram_we     = 1'b1;
                                ram_waddr  = ring_slot(head_reg, count_reg);
                            end
                        end
                        CMD_POP_FRONT:
                        begin
                            if (is_empty)
                            begin
                                out_next.kind = KIND_EMPTY;
                            end
                            else
                            begin
                                head_next  = ring_slot(head_reg, CNT_W'(1));
                                count_next = count_reg - 1'b1;
                            end
                        end
                        CMD_POP_BACK:
                        begin
                            if (is_empty)
                            begin
                                out_next.kind = KIND_EMPTY;
                            end
                            else
                            begin
                                count_next = count_reg - 1'b1;
                            end
                        end
                        CMD_CLEAR:
                        begin
                            head_next  = '0;
                            count_next = '0;
                        end
                        CMD_REMOVE:
                        begin
                            state_next = S_REMOVE;
                            idx_next   = '0;
                            wr_next    = '0;
                        end
                        CMD_READ_FIRST, CMD_READ_LAST:
                        begin
                            if (rd_n == '0)
                            begin
                                out_next.kind = KIND_NONE;
                            end
                            else
                            begin
                                state_next = S_RD_FIRST;
                                n_next     = rd_n;
                                idx_next   = '0;
                                start_next = (cmd_e_t'(in_data.cmd) == CMD_READ_FIRST)
                                             ? '0 : count_reg - rd_n;
                            end
                        end
                    endcase
                    out_next.length = LEN_W'(count_next);
                    // remove and non-empty reads report later
                    out_valid_next  = (state_next == S_IDLE);
                end
            end

            S_REMOVE:
            begin
                // read entry idx while the compare looks at entry idx - 1
                if (idx_reg < count_reg)
                begin
                    ram_re    = 1'b1;
                    idx_next  = idx_reg + 1'b1;
                    pend_next = 1'b1;
                end
                if (pend_reg && (ram_rdata != VAL_W'(value_reg)))
                begin
                    ram_we    = 1'b1;
                    ram_wdata = ram_rdata;
                    wr_next   = wr_reg + 1'b1;
                end
                if (!(idx_reg < count_reg) && !pend_reg)
                begin
                    count_next         = wr_reg;
                    state_next         = S_IDLE;
                    out_valid_next     = 1'b1;
                    out_next.kind      = KIND_DONE;
                    out_next.out_value = '0;
                    out_next.length    = LEN_W'(wr_reg);
                    out_next.is_last   = 1'b1;
                end
            end

            S_RD_FIRST:
            begin
                ram_re     = 1'b1;
                ram_raddr  = ring_slot(head_reg, rd_off);
                state_next = S_RD_EMIT;
            end

            S_RD_EMIT:
            begin
                if (out_free)
                begin
                    out_valid_next     = 1'b1;
                    out_next.kind      = KIND_ELEMENT;
                    out_next.out_value = ram_rdata;
                    out_next.length    = LEN_W'(count_reg);
                    out_next.is_last   = (idx_reg + 1'b1 == n_reg);
                    if (idx_reg + 1'b1 == n_reg)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        // fetch the following entry as this one goes out
                        idx_next  = idx_reg + 1'b1;
                        rd_off    = start_reg + idx_reg + 1'b1;
                        ram_re    = 1'b1;
                        ram_raddr = ring_slot(head_reg, rd_off);
                    end
                end
            end
        endcase
    end

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("entry count above capacity");

    a_compact_behind: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_REMOVE) |-> (wr_reg <= idx_reg))
        else $error("compaction write pointer ahead of read pointer");

    a_no_rw_clash: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_REMOVE && ram_we && ram_re) |-> (ram_waddr != ram_raddr))
        else $error("remove walk wrote the entry being read");

    a_remove_shrinks: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_REMOVE && state_next == S_IDLE)
        |=> (count_reg <= $past(count_reg)))
        else $error("remove grew the queue");

    a_read_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_RD_EMIT) |-> (idx_reg < n_reg && n_reg <= count_reg))
        else $error("read walk beyond its length");
`endif

endmodule

/* verif/deque_with_value_delete_core_test.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// deque_with_value_delete_core_test
// Self-checking bench for the double-ended queue core. A short table of
// directed commands covers the empty and single-entry corners, extreme words,
// clamped reads and removal of repeated values. Random phases that fill, mix
// and drain then drive the queue to full and back to empty. A shadow queue
// predicts every result beat, and both channels see random stall bursts.
// ----------------------------------------------------------------------------
module deque_with_value_delete_core_test;
    import dq_pkg::*;

    localparam int QUEUE_DEPTH  = 32;
    localparam int RANDOM_ITEMS = 400;
    localparam int QUIET_TAIL   = 60;
    localparam int STALL_LIMIT  = 2000;
    localparam int DRAIN_CYCLES = 50;

    typedef enum int { PH_FILL, PH_MIXED, PH_DRAIN } phase_e_t;

    typedef struct packed {
        in_t              stim;
        bit               typed;
        kind_e_t          want_kind;
        logic [LEN_W-1:0] want_len;
    } row_t;

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_ready;
    in_t  in_data;
    logic out_valid;
    logic out_ready;
    out_t out_data;

    logic signed [VAL_W-1:0] queue_shadow[$];
    out_t                    cmd_results[$];
    out_t                    pending_results[$];
    row_t                    directed_rows[$];
    out_t                    oldest_result;
    bit                      idle_en;
    int                      errors;
    int                      quiet_cycles;

    deque_with_value_delete_core #(
        .DEPTH(QUEUE_DEPTH)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .in_data(in_data),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .out_data(out_data)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // result beats that the command causes, and the shadow queue after it
    task automatic predict_deque(input in_t c);
        logic signed [VAL_W-1:0] kept[$];
        out_t r;
        int n;
        int first;
        cmd_results.delete();
        r.kind = KIND_DONE;
        r.out_value = '0;
        r.is_last = 1'b1;
        case (cmd_e_t'(c.cmd))
            CMD_PUSH_FRONT, CMD_PUSH_BACK:
            begin
                if (queue_shadow.size() >= QUEUE_DEPTH)
                    r.kind = KIND_FULL;
                else if (c.cmd == CMD_PUSH_FRONT)
                    queue_shadow.push_front(c.item_value);
                else
                    queue_shadow.push_back(c.item_value);
            end
            CMD_POP_FRONT, CMD_POP_BACK:
            begin
                if (queue_shadow.size() == 0)
                    r.kind = KIND_EMPTY;
                else if (c.cmd == CMD_POP_FRONT)
                    void'(queue_shadow.pop_front());
                else
                    void'(queue_shadow.pop_back());
            end
            CMD_CLEAR:
                queue_shadow.delete();
            CMD_REMOVE:
            begin
                foreach (queue_shadow[i])
                    if (queue_shadow[i] != c.item_value)
                        kept.push_back(queue_shadow[i]);
                queue_shadow = kept;
            end
            default:
            begin
                n = (c.read_count < queue_shadow.size()) ? c.read_count : queue_shadow.size();
                if (n == 0)
                    r.kind = KIND_NONE;
                else
                begin
                    first = (c.cmd == CMD_READ_FIRST) ? 0 : queue_shadow.size() - n;
                    for (int i = 0; i < n; i++)
                    begin
                        r.kind = KIND_ELEMENT;
                        r.out_value = queue_shadow[first + i];
                        r.length = LEN_W'(queue_shadow.size());
                        r.is_last = (i == n - 1);
                        cmd_results.push_back(r);
                    end
                    return;
                end
            end
        endcase
        r.length = LEN_W'(queue_shadow.size());
        cmd_results.push_back(r);
    endtask

    task automatic add_row(input cmd_e_t cmd, input logic signed [VAL_W-1:0] value,
                           input int count, input int typed, input kind_e_t kind,
                           input int len);
        row_t row;
        row.stim.cmd = cmd;
        row.stim.item_value = value;
        row.stim.read_count = LEN_W'(count);
        row.typed = (typed != 0);
        row.want_kind = kind;
        row.want_len = LEN_W'(len);
        directed_rows.push_back(row);
    endtask

    // called at a falling edge, returns at the falling edge after the beat
    task automatic send_cmd(input in_t c, input bit typed, input kind_e_t want_kind,
                            input logic [LEN_W-1:0] want_len);
        out_t r;
        if (idle_en && $urandom_range(0, 4) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(negedge clk);
        end
        in_valid <= 1'b1;
        in_data <= c;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        predict_deque(c);
        if (typed)
        begin
            r.kind = want_kind;
            r.out_value = '0;
            r.length = want_len;
            r.is_last = 1'b1;
            pending_results.push_back(r);
        end
        else
            foreach (cmd_results[i])
                pending_results.push_back(cmd_results[i]);
        @(negedge clk);
    endtask

    function automatic logic signed [VAL_W-1:0] pick_value();
        case ($urandom_range(0, 9))
            0: pick_value = 32'sh7fffffff;
            1: pick_value = 32'sh80000000;
            2, 3, 4: pick_value = int'($urandom_range(0, 4)) - 2;
            default: pick_value = $urandom();
        endcase
    endfunction

    function automatic logic [LEN_W-1:0] pick_count();
        int top;
        top = queue_shadow.size() + 2;
        case ($urandom_range(0, 9))
            0: pick_count = LEN_W'(64);
            1: pick_count = LEN_W'($urandom_range(33, 64));
            2, 3: pick_count = LEN_W'($urandom_range(0, top));
            default: pick_count = LEN_W'($urandom_range(0, 8));
        endcase
    endfunction

    function automatic in_t random_cmd(input phase_e_t ph);
        in_t c;
        int unsigned roll;
        int p_push;
        int p_pop;
        int p_read;
        int p_remove;
        roll = $urandom_range(0, 99);
        case (ph)
            PH_FILL:
            begin
                p_push = 72;
                p_pop = 10;
                p_read = 12;
                p_remove = 6;
            end
            PH_DRAIN:
            begin
                p_push = 10;
                p_pop = 60;
                p_read = 15;
                p_remove = 12;
            end
            default:
            begin
                p_push = 35;
                p_pop = 30;
                p_read = 20;
                p_remove = 12;
            end
        endcase
        c.item_value = pick_value();
        c.read_count = pick_count();
        if (roll < p_push)
            c.cmd = $urandom_range(0, 1) ? CMD_PUSH_BACK : CMD_PUSH_FRONT;
        else if (roll < p_push + p_pop)
            c.cmd = $urandom_range(0, 1) ? CMD_POP_BACK : CMD_POP_FRONT;
        else if (roll < p_push + p_pop + p_read)
            c.cmd = $urandom_range(0, 1) ? CMD_READ_LAST : CMD_READ_FIRST;
        else if (roll < p_push + p_pop + p_read + p_remove)
        begin
            c.cmd = CMD_REMOVE;
            // mostly hit a value that is actually held
            if (queue_shadow.size() > 0 && $urandom_range(0, 2) != 0)
                c.item_value = queue_shadow[$urandom_range(0, queue_shadow.size() - 1)];
        end
        else
            c.cmd = CMD_CLEAR;
        return c;
    endfunction

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_results.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected beat: kind %0d value %0d length %0d last %0b",
                         $time, out_data.kind, out_data.out_value, out_data.length,
                         out_data.is_last);
            end
            else
            begin
                oldest_result = pending_results.pop_front();
                if (out_data.kind !== oldest_result.kind
                    || out_data.out_value !== oldest_result.out_value
                    || out_data.length !== oldest_result.length
                    || out_data.is_last !== oldest_result.is_last)
                begin
                    errors++;
                    $display("%0t: mismatch: expected kind %0d value %0d length %0d last %0b",
                             $time, oldest_result.kind, oldest_result.out_value,
                             oldest_result.length, oldest_result.is_last);
                    $display("%0t:           actual   kind %0d value %0d length %0d last %0b",
                             $time, out_data.kind, out_data.out_value, out_data.length,
                             out_data.is_last);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || !rst_n)
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("%0t: no beat for %0d cycles, %0d results outstanding",
                     $time, quiet_cycles, pending_results.size());
            $display("FAIL deque_with_value_delete_core");
            $finish;
        end
    end

    initial
    begin
        out_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (idle_en && $urandom_range(0, 5) == 0)
            begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 10)) @(negedge clk);
            end
            out_ready <= 1'b1;
        end
    end

    initial
    begin
        phase_e_t ph;
        int phase_left;
        int phase_idx;
        int sent;
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_data = '0;
        idle_en = 1'b1;
        errors = 0;
        quiet_cycles = 0;

        // empty queue corners
        add_row(CMD_POP_FRONT,  0, 0, 1, KIND_EMPTY, 0);
        add_row(CMD_POP_BACK,   -1, 0, 1, KIND_EMPTY, 0);
        add_row(CMD_READ_FIRST, 0, 5, 1, KIND_NONE, 0);
        add_row(CMD_READ_LAST,  0, 64, 1, KIND_NONE, 0);
        add_row(CMD_REMOVE,     0, 0, 1, KIND_DONE, 0);
        add_row(CMD_CLEAR,      0, 0, 1, KIND_DONE, 0);
        // extremes at both ends, front push wraps the head below zero
        add_row(CMD_PUSH_FRONT, 32'sh7fffffff, 0, 1, KIND_DONE, 1);
        add_row(CMD_PUSH_BACK,  32'sh80000000, 0, 1, KIND_DONE, 2);
        add_row(CMD_PUSH_FRONT, -1, 0, 1, KIND_DONE, 3);
        add_row(CMD_PUSH_BACK,  0, 127, 1, KIND_DONE, 4);
        add_row(CMD_PUSH_BACK,  -1, 0, 1, KIND_DONE, 5);
        // reads, clamped and partial
        add_row(CMD_READ_FIRST, 0, 64, 0, KIND_DONE, 0);
        add_row(CMD_READ_LAST,  0, 2, 0, KIND_DONE, 0);
        add_row(CMD_READ_FIRST, 0, 0, 1, KIND_NONE, 5);
        add_row(CMD_READ_LAST,  0, 1, 0, KIND_DONE, 0);
        // absent value, then two copies at both ends
        add_row(CMD_REMOVE,     12345, 0, 1, KIND_DONE, 5);
        add_row(CMD_REMOVE,     -1, 0, 1, KIND_DONE, 3);
        add_row(CMD_READ_FIRST, 0, 3, 0, KIND_DONE, 0);
        add_row(CMD_POP_BACK,   0, 0, 1, KIND_DONE, 2);
        add_row(CMD_POP_FRONT,  0, 0, 1, KIND_DONE, 1);
        add_row(CMD_POP_FRONT,  0, 0, 1, KIND_DONE, 0);
        // remove that empties a single-entry queue
        add_row(CMD_PUSH_FRONT, 5, 0, 1, KIND_DONE, 1);
        add_row(CMD_REMOVE,     5, 0, 1, KIND_DONE, 0);
        add_row(CMD_PUSH_BACK,  1, 0, 1, KIND_DONE, 1);
        add_row(CMD_CLEAR,      0, 0, 1, KIND_DONE, 0);

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (directed_rows[i])
            send_cmd(directed_rows[i].stim, directed_rows[i].typed,
                     directed_rows[i].want_kind, directed_rows[i].want_len);

        sent = 0;
        phase_left = 0;
        phase_idx = 0;
        while (sent < RANDOM_ITEMS)
        begin
            if (phase_left == 0)
            begin
                ph = phase_e_t'(phase_idx % 3);
                phase_idx++;
                phase_left = (ph == PH_FILL) ? $urandom_range(45, 70) : $urandom_range(20, 50);
            end
            if (sent == RANDOM_ITEMS - QUIET_TAIL)
                idle_en = 1'b0;
            send_cmd(random_cmd(ph), 1'b0, KIND_DONE, '0);
            sent++;
            phase_left--;
        end
        in_valid <= 1'b0;

        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (errors == 0)
            $display("PASS deque_with_value_delete_core");
        else
            $display("FAIL deque_with_value_delete_core");
        $finish;
    end

endmodule
